// ===== rtl/lprd_pkg.sv =====
// shared types, constants and pointer helpers for the length prefix ring deframer
// no dependencies; used by the controller, the datapath and the top level
package lprd_pkg;

   localparam int RING_DEPTH   = 4096;
   localparam int PTR_W        = $clog2(RING_DEPTH);
   localparam int CAPACITY     = RING_DEPTH - 1;
   localparam int HEADER_BYTES = 4;
   localparam int LEN_W        = 8 * HEADER_BYTES;
   localparam int FREE_W       = 12;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_DRAIN = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      STATUS_BYTE_OUT = 3'd0,
      STATUS_NOTHING  = 3'd1,
      STATUS_PUSHED   = 3'd2,
      STATUS_DROPPED  = 3'd3,
      STATUS_TOO_LONG = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_HDR_END,
      S_HDR_CHK,
      S_READ
   } ctl_state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_PUSH,
      DP_TAKE_FRAME,
      DP_TAKE_DRAIN,
      DP_HDR_READ,
      DP_START_FRAME
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] hdr_off;
      logic       hdr_shift;
      logic       load_resp;
      status_type resp_status;
      logic       resp_from_mem;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic store_full;
      logic store_nonempty;
      logic count_ge_header;
      logic frame_active;
      logic hdr_too_long;
      logic frame_complete;
   } dp_stat_type;

   // position plus a small offset, wrapped at the ring depth
   function automatic ptr_type ptr_add(ptr_type p, logic [1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, p} + {{(PTR_W-1){1'b0}}, off};
      if (sum >= (PTR_W+1)'(RING_DEPTH)) begin
         sum = sum - (PTR_W+1)'(RING_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   function automatic ptr_type stored_count(ptr_type rp, ptr_type wp);
      logic [PTR_W:0] diff;
      if (wp >= rp) begin
         diff = {1'b0, wp} - {1'b0, rp};
      end else begin
         diff = {1'b0, wp} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rp};
      end
      return diff[PTR_W-1:0];
   endfunction

endpackage

// ===== rtl/lprd_channels.sv =====
// valid/ready channel interfaces for the request and response items
// no dependencies
interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface lprd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last_of_frame;
   logic [2:0]  status;
   logic [11:0] free_space;
   logic        store_empty;

   modport source (output valid, output out_byte, output last_of_frame, output status,
                   output free_space, output store_empty, input ready);
   modport sink (input valid, input out_byte, input last_of_frame, input status,
                 input free_space, input store_empty, output ready);
endinterface

// ===== rtl/lprd_dpath.sv =====
// datapath: ring store, read and write positions, frame counter, header
// assembly and the response register; depends on lprd_pkg
module lprd_dpath import lprd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [7:0]        data_byte,
   input  logic              rsp_ready,
   output dp_stat_type       stat,
   output logic              rsp_valid,
   output logic [7:0]        out_byte,
   output logic              last_of_frame,
   output logic [2:0]        status,
   output logic [FREE_W-1:0] free_space,
   output logic              store_empty
);

   logic [7:0]        ring_mem [RING_DEPTH];
   logic [7:0]        rd_data_ff;

   ptr_type           rp_ff, rp_in;
   ptr_type           wp_ff, wp_in;
   ptr_type           fbl_ff, fbl_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              last_pend_ff, last_pend_in;

   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   status_type        status_ff, status_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic              empty_ff, empty_in;

   logic              wr_en;
   logic              rd_en;
   ptr_type           rd_addr;
   ptr_type           count;
   ptr_type           rp_inc;
   logic [31:0]       free_wide;
   logic [LEN_W:0]    frame_total;

   assign count  = stored_count(rp_ff, wp_ff);
   assign rp_inc = ptr_add(rp_ff, 2'd1);

   assign frame_total = {1'b0, len_ff} + (LEN_W+1)'(HEADER_BYTES);

   assign stat.slot_free       = !valid_ff || rsp_ready;
   assign stat.store_full      = (count == PTR_W'(CAPACITY));
   assign stat.store_nonempty  = (count != '0);
   assign stat.count_ge_header = (count >= PTR_W'(HEADER_BYTES));
   assign stat.frame_active    = (fbl_ff != '0);
   assign stat.hdr_too_long    = (len_ff > LEN_W'(CAPACITY - HEADER_BYTES));
   assign stat.frame_complete  = ((LEN_W+1)'(count) >= frame_total);

   always_comb begin
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fbl_in       = fbl_ff;
      len_in       = len_ff;
      last_pend_in = last_pend_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = rp_ff;

      case (cmd.op)
         DP_PUSH: begin
            wr_en = 1'b1;
            wp_in = ptr_add(wp_ff, 2'd1);
         end
         DP_TAKE_FRAME: begin
            rd_en        = 1'b1;
            rp_in        = rp_inc;
            fbl_in       = fbl_ff - PTR_W'(1);
            last_pend_in = (fbl_in == '0);
         end
         DP_TAKE_DRAIN: begin
            rd_en        = 1'b1;
            rp_in        = rp_inc;
            fbl_in       = '0;
            last_pend_in = (rp_inc == wp_ff);
         end
         DP_HDR_READ: begin
            rd_en   = 1'b1;
            rd_addr = ptr_add(rp_ff, cmd.hdr_off);
         end
         DP_START_FRAME: begin
            // frame length counts the header; the first header byte is read now
            rd_en        = 1'b1;
            rp_in        = rp_inc;
            fbl_in       = frame_total[PTR_W-1:0] - PTR_W'(1);
            last_pend_in = (fbl_in == '0);
         end
         default: begin
         end
      endcase

      if (cmd.hdr_shift) begin
         len_in = {len_ff[LEN_W-9:0], rd_data_ff};
      end
   end

   // response register, loaded from the positions as they stand after this item
   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      status_in = status_ff;
      free_in   = free_ff;
      empty_in  = empty_ff;
      free_wide = 32'(CAPACITY) - 32'(stored_count(rp_in, wp_in));
      if (cmd.load_resp) begin
         valid_in  = 1'b1;
         byte_in   = cmd.resp_from_mem ? rd_data_ff : 8'd0;
         last_in   = cmd.resp_from_mem ? last_pend_ff : 1'b0;
         status_in = cmd.resp_status;
         free_in   = free_wide[FREE_W-1:0];
         empty_in  = (rp_in == wp_in);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wp_ff] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff    <= '0;
         wp_ff    <= '0;
         fbl_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         fbl_ff   <= fbl_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      last_pend_ff <= last_pend_in;
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
      free_ff      <= free_in;
      empty_ff     <= empty_in;
   end

   assign rsp_valid     = valid_ff;
   assign out_byte      = byte_ff;
   assign last_of_frame = last_ff;
   assign status        = status_ff;
   assign free_space    = free_ff;
   assign store_empty   = empty_ff;

   // a frame in progress is always fully held in the store
   a_frame_stored: assert property (@(posedge clock) disable iff (reset)
      (fbl_ff != '0) |-> (count >= fbl_ff))
      else $error("frame in progress not fully stored");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_PUSH) |-> !stat.store_full)
      else $error("push issued into a full store");

   a_take_then_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_TAKE_FRAME || cmd.op == DP_TAKE_DRAIN || cmd.op == DP_START_FRAME)
      |=> (cmd.load_resp && cmd.resp_from_mem))
      else $error("byte read not followed by a response load");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_resp |-> stat.slot_free)
      else $error("response loaded over a pending item");

endmodule

// ===== rtl/lprd_ctrl.sv =====
// controller state machine: decodes commands, sequences header fetch and
// byte reads, issues datapath commands; depends on lprd_pkg
module lprd_ctrl import lprd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_command,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;
   logic [1:0]    step_ff, step_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && stat.slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in          = state_ff;
      step_in           = step_ff;
      cmd.op            = DP_NONE;
      cmd.hdr_off       = step_ff;
      cmd.hdr_shift     = 1'b0;
      cmd.load_resp     = 1'b0;
      cmd.resp_status   = STATUS_NOTHING;
      cmd.resp_from_mem = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_PUSH: begin
                     cmd.load_resp = 1'b1;
                     if (stat.store_full) begin
                        cmd.resp_status = STATUS_DROPPED;
                     end else begin
                        cmd.op          = DP_PUSH;
                        cmd.resp_status = STATUS_PUSHED;
                     end
                  end
                  CMD_POP: begin
                     if (stat.frame_active) begin
                        cmd.op   = DP_TAKE_FRAME;
                        state_in = S_READ;
                     end else if (stat.count_ge_header) begin
                        cmd.op      = DP_HDR_READ;
                        cmd.hdr_off = 2'd0;
                        step_in     = 2'd1;
                        state_in    = S_HDR;
                     end else begin
                        cmd.load_resp = 1'b1;
                     end
                  end
                  CMD_DRAIN: begin
                     if (stat.store_nonempty) begin
                        cmd.op   = DP_TAKE_DRAIN;
                        state_in = S_READ;
                     end else begin
                        cmd.load_resp = 1'b1;
                     end
                  end
                  default: begin
                     cmd.load_resp = 1'b1;
                  end
               endcase
            end
         end
         S_HDR: begin
            // read the next header byte while the previous one shifts in
            cmd.op        = DP_HDR_READ;
            cmd.hdr_shift = 1'b1;
            step_in       = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = S_HDR_END;
            end
         end
         S_HDR_END: begin
            cmd.hdr_shift = 1'b1;
            state_in      = S_HDR_CHK;
         end
         S_HDR_CHK: begin
            if (stat.hdr_too_long) begin
               cmd.load_resp   = 1'b1;
               cmd.resp_status = STATUS_TOO_LONG;
               state_in        = S_IDLE;
            end else if (stat.frame_complete) begin
               cmd.op   = DP_START_FRAME;
               state_in = S_READ;
            end else begin
               cmd.load_resp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            cmd.load_resp     = 1'b1;
            cmd.resp_status   = STATUS_BYTE_OUT;
            cmd.resp_from_mem = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_pop_in_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_POP && stat.frame_active) |=> (state_ff == S_READ))
      else $error("pop within a frame did not go to the byte read");

   a_hdr_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HDR && step_ff == 2'd3) |=> (state_ff == S_HDR_END))
      else $error("header fetch did not finish after four reads");

   a_read_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_IDLE))
      else $error("byte read did not return to idle");

endmodule

// ===== rtl/length_prefix_ring_deframer.sv =====
// push, unused command, drain of an empty store or pop with under four bytes stored
// answer in the cycle after accept, one item per cycle; a raw or in-frame byte is read, then
// answered; a pop that starts a frame does four header reads, length check, first byte read;
// an oversize or incomplete frame ends at the check; a new item waits for a free slot
// reset is synchronous: positions and frame counter clear to zero, the store is not cleared
// top level: joins controller and datapath; depends on lprd_pkg and lprd_channels
module length_prefix_ring_deframer import lprd_pkg::*; (
   input logic         clock,
   input logic         reset,
   lprd_req_if.sink    req_ch,
   lprd_rsp_if.source  rsp_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lprd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   lprd_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .data_byte     (req_ch.data_byte),
      .rsp_ready     (rsp_ch.ready),
      .stat          (stat),
      .rsp_valid     (rsp_ch.valid),
      .out_byte      (rsp_ch.out_byte),
      .last_of_frame (rsp_ch.last_of_frame),
      .status        (rsp_ch.status),
      .free_space    (rsp_ch.free_space),
      .store_empty   (rsp_ch.store_empty)
   );

endmodule

// ===== test/tb_length_prefix_ring_deframer.sv =====
// testbench for the length prefix ring deframer: push, frame pop, drain and unused commands
// checked item by item against a behavioural copy of the ring, positions and frame counter
// depends on lprd_pkg, lprd_channels and the rtl top level
module tb_length_prefix_ring_deframer;
   timeunit 1ns;
   timeprecision 1ps;
   import lprd_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int GAP_MAX      = 5;
   localparam int LONG_HOLD    = 60;
   localparam int RANDOM_ITEMS = 1000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      logic [1:0] command;
      logic [7:0] data_byte;
      bit         settle;
   } cmd_item_type;

   typedef struct {
      logic [7:0]        out_byte;
      logic              last_of_frame;
      status_type        status;
      logic [FREE_W-1:0] free_space;
      logic              store_empty;
   } deframe_rsp_type;

   logic clock;
   logic reset;

   lprd_req_if req_ch ();
   lprd_rsp_if rsp_ch ();

   length_prefix_ring_deframer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   cmd_item_type    cmd_backlog[$];
   deframe_rsp_type due_responses[$];

   // behavioural copy of the ring
   logic [7:0]  ring_copy [RING_DEPTH];
   ptr_type     rd_pos;
   ptr_type     wr_pos;
   int unsigned bytes_to_go;

   int unsigned queued_items;
   int unsigned responses_seen;
   int unsigned long_hold_at;
   int unsigned fails;
   int unsigned frames_out;
   int unsigned drained_bytes;
   int unsigned dropped_pushes;
   int unsigned oversize_headers;
   bit          settle_next;

   int unsigned     send_gap;
   bit              send_calm;
   cmd_item_type    next_item;
   int unsigned     take_hold;
   int unsigned     hold_now;
   bit              take_calm;
   deframe_rsp_type want;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ring depth is a power of two, so pointer arithmetic wraps by itself
   function automatic void deframe_item(logic [1:0] cmd, logic [7:0] data);
      deframe_rsp_type  r;
      int unsigned      held;
      logic [LEN_W-1:0] frame_len;
      r.out_byte      = '0;
      r.last_of_frame = 1'b0;
      r.status        = STATUS_NOTHING;
      held = 32'(ptr_type'(wr_pos - rd_pos));
      if (cmd == CMD_PUSH) begin
         if (held >= CAPACITY) begin
            r.status = STATUS_DROPPED;
            dropped_pushes++;
         end else begin
            ring_copy[wr_pos] = data;
            wr_pos = wr_pos + 1'b1;
            r.status = STATUS_PUSHED;
         end
      end else if (cmd == CMD_POP) begin
         if (bytes_to_go == 0 && held >= HEADER_BYTES) begin
            frame_len = {ring_copy[rd_pos], ring_copy[ptr_type'(rd_pos + 1)],
                         ring_copy[ptr_type'(rd_pos + 2)], ring_copy[ptr_type'(rd_pos + 3)]};
            if (frame_len > CAPACITY - HEADER_BYTES) begin
               r.status = STATUS_TOO_LONG;
               oversize_headers++;
            end else if (held >= HEADER_BYTES + frame_len) begin
               bytes_to_go = HEADER_BYTES + frame_len;
            end
         end
         if (bytes_to_go != 0 && held != 0) begin
            r.out_byte = ring_copy[rd_pos];
            rd_pos = rd_pos + 1'b1;
            bytes_to_go--;
            r.last_of_frame = (bytes_to_go == 0);
            r.status = STATUS_BYTE_OUT;
            if (bytes_to_go == 0) frames_out++;
         end
      end else if (cmd == CMD_DRAIN) begin
         if (held != 0) begin
            bytes_to_go = 0;
            r.out_byte = ring_copy[rd_pos];
            rd_pos = rd_pos + 1'b1;
            r.last_of_frame = (rd_pos == wr_pos);
            r.status = STATUS_BYTE_OUT;
            drained_bytes++;
         end
      end
      held = 32'(ptr_type'(wr_pos - rd_pos));
      r.free_space  = FREE_W'(CAPACITY - held);
      r.store_empty = (rd_pos == wr_pos);
      due_responses.push_back(r);
   endfunction

   function automatic void queue_item(logic [1:0] cmd, logic [7:0] data);
      cmd_item_type it;
      it.command   = cmd;
      it.data_byte = data;
      it.settle    = settle_next;
      settle_next  = 1'b0;
      if (cmd != CMD_UNUSED) queued_items++;
      cmd_backlog.push_back(it);
   endfunction

   // data is random; it only matters for pushes
   function automatic void queue_repeat(logic [1:0] cmd, int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         queue_item(cmd, 8'($urandom_range(0, 255)));
      end
   endfunction

   // big-endian length header
   function automatic void queue_header(logic [31:0] len);
      queue_item(CMD_PUSH, len[31:24]);
      queue_item(CMD_PUSH, len[23:16]);
      queue_item(CMD_PUSH, len[15:8]);
      queue_item(CMD_PUSH, len[7:0]);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            deframe_item(req_ch.command, req_ch.data_byte);
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].settle && due_responses.size() != 0)) begin
               next_item = cmd_backlog.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.command   <= next_item.command;
               req_ch.data_byte <= next_item.data_byte;
               if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
               send_gap <= send_calm ? 0 : $urandom_range(0, GAP_MAX);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_hold <= 0;
      end else begin
         hold_now = take_hold;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_responses.size() == 0) begin
               $error("response with none due: status %0d byte %0d",
                      rsp_ch.status, rsp_ch.out_byte);
               fails++;
            end else begin
               want = due_responses.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_ch.out_byte);
                  fails++;
               end
               if (rsp_ch.last_of_frame !== want.last_of_frame) begin
                  $error("last_of_frame: expected %0d, got %0d",
                         want.last_of_frame, rsp_ch.last_of_frame);
                  fails++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  fails++;
               end
               if (rsp_ch.free_space !== want.free_space) begin
                  $error("free_space: expected %0d, got %0d",
                         want.free_space, rsp_ch.free_space);
                  fails++;
               end
               if (rsp_ch.store_empty !== want.store_empty) begin
                  $error("store_empty: expected %0d, got %0d",
                         want.store_empty, rsp_ch.store_empty);
                  fails++;
               end
            end
            responses_seen++;
            // one long back-pressure stretch so the input side stalls
            if (responses_seen == long_hold_at) begin
               hold_now = LONG_HOLD;
            end else begin
               if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
               hold_now = take_calm ? 0 : $urandom_range(0, GAP_MAX);
            end
         end
         if (hold_now != 0) begin
            rsp_ch.ready <= 1'b0;
            take_hold <= hold_now - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            take_hold <= 0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_length_prefix_ring_deframer NOT OK");
      $finish;
   end

   initial begin
      int unsigned pick;
      int unsigned frame_len;
      int unsigned split;
      int unsigned target;
      logic [31:0] bad_len;
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_PUSH;
      req_ch.data_byte = '0;
      rsp_ch.ready     = 1'b0;
      reset            = 1'b1;
      rd_pos = '0;
      wr_pos = '0;
      bytes_to_go = 0;

      // empty store, unused command, short header, zero length frame
      queue_item(CMD_POP, 8'h00);
      queue_item(CMD_DRAIN, 8'h00);
      queue_item(CMD_UNUSED, 8'hFF);
      queue_item(CMD_PUSH, 8'h00);
      queue_item(CMD_PUSH, 8'h00);
      queue_item(CMD_PUSH, 8'h00);
      queue_item(CMD_POP, 8'h00);
      queue_item(CMD_PUSH, 8'h00);
      queue_repeat(CMD_POP, HEADER_BYTES);
      // header stored without its payload, then the payload; a drain abandons the started frame
      queue_header(32'd1);
      queue_item(CMD_POP, 8'h00);
      queue_item(CMD_PUSH, 8'hFF);
      queue_repeat(CMD_POP, 2);
      queue_repeat(CMD_DRAIN, 3);

      // smallest oversize header, then the largest frame that fits, filling the store
      settle_next = 1'b1;
      queue_header(CAPACITY - HEADER_BYTES + 1);
      queue_item(CMD_POP, 8'h00);
      queue_repeat(CMD_DRAIN, HEADER_BYTES);
      queue_header(CAPACITY - HEADER_BYTES);
      queue_item(CMD_POP, 8'h00);
      queue_repeat(CMD_PUSH, CAPACITY - HEADER_BYTES);
      queue_item(CMD_PUSH, 8'h00);
      queue_item(CMD_PUSH, 8'hFF);
      queue_repeat(CMD_PUSH, 1);
      queue_repeat(CMD_POP, CAPACITY + 1);

      settle_next = 1'b1;
      long_hold_at = cmd_backlog.size() + 150;
      target = queued_items + RANDOM_ITEMS;
      while (queued_items < target) begin
         if ($urandom_range(0, 29) == 0) settle_next = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200)
                                                     : $urandom_range(0, 12);
            queue_header(frame_len);
            queue_repeat(CMD_PUSH, frame_len);
            if ($urandom_range(0, 9) < 7) begin
               queue_repeat(CMD_POP, HEADER_BYTES + frame_len + $urandom_range(0, 1));
            end
         end else if (pick < 55) begin
            // pop while the payload is only partly stored
            frame_len = $urandom_range(1, 10);
            split = $urandom_range(0, frame_len - 1);
            queue_header(frame_len);
            queue_repeat(CMD_PUSH, split);
            queue_item(CMD_POP, 8'h00);
            queue_repeat(CMD_PUSH, frame_len - split);
            queue_repeat(CMD_POP, HEADER_BYTES + frame_len);
         end else if (pick < 70) begin
            queue_repeat(CMD_POP, $urandom_range(1, 6));
         end else if (pick < 80) begin
            queue_repeat(CMD_PUSH, $urandom_range(1, 3));
         end else if (pick < 88) begin
            queue_repeat(CMD_DRAIN, $urandom_range(1, 8));
         end else if (pick < 93) begin
            case ($urandom_range(0, 2))
               0: bad_len = 32'hFFFF_FFFF;
               1: bad_len = $urandom_range(CAPACITY - HEADER_BYTES + 1, 65535);
               default: bad_len = $urandom() | 32'h8000_0000;
            endcase
            queue_header(bad_len);
            queue_item(CMD_POP, 8'h00);
            queue_repeat(CMD_DRAIN, HEADER_BYTES);
         end else if (pick < 96) begin
            queue_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
         end else begin
            queue_repeat(CMD_DRAIN, 24);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // sampled between edges so the sender and receiver updates have landed
      while (cmd_backlog.size() != 0 || req_ch.valid || due_responses.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d responses: %0d whole frames, %0d drained bytes,",
               responses_seen, frames_out, drained_bytes);
      $display("  %0d pushes dropped on a full store, %0d oversize headers seen",
               dropped_pushes, oversize_headers);
      if (fails == 0 && due_responses.size() == 0) begin
         $display("tb_length_prefix_ring_deframer OK");
      end else begin
         $display("tb_length_prefix_ring_deframer NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lprd_pkg.sv
rtl/lprd_channels.sv
rtl/lprd_dpath.sv
rtl/lprd_ctrl.sv
rtl/length_prefix_ring_deframer.sv
test/tb_length_prefix_ring_deframer.sv
